[design/cad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_pkg: shared types and constants for the calendar date block
// widths, year bounds, command codes, sequencer states and month tables
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int CMD_W   = 2;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 15;
  localparam int YLEN_W  = 9;

  localparam logic [YEAR_W-1:0]  YEAR_LO    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_HI    = 14'd9999;
  localparam logic [MONTH_W-1:0] FIRST_MON  = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MON   = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_BACK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  // days in a month of a given year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      len = 5'd30;
    end else if (month == 4'd2) begin
      len = is_leap(year) ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

  // days in a whole year
  function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] year);
    return is_leap(year) ? 9'd366 : 9'd365;
  endfunction

endpackage

[design/cad_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_req_if: command channel
// valid/ready handshake carrying one date command
// ----------------------------------------------------------------------------
interface cad_req_if
  import cad_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [YEAR_W-1:0]  new_year;
  logic [MONTH_W-1:0] new_month;
  logic [DAY_W-1:0]   new_day;
  logic [COUNT_W-1:0] day_count;

  modport source (
    output valid, cmd, new_year, new_month, new_day, day_count,
    input  ready
  );

  modport sink (
    input  valid, cmd, new_year, new_month, new_day, day_count,
    output ready
  );
endinterface

[design/cad_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_rsp_if: result channel
// valid/ready handshake carrying the date after each command
// ----------------------------------------------------------------------------
interface cad_rsp_if
  import cad_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic               year_limited;

  modport source (
    output valid, cur_year, cur_month, cur_day, year_limited,
    input  ready
  );

  modport sink (
    input  valid, cur_year, cur_month, cur_day, year_limited,
    output ready
  );
endinterface

[design/calendar_date_add_days.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days: calendar date register with load, add and step back
// holds one date; adds day counts by walking whole years and months with a
// single shared subtract and compare unit under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    cmd, new_year, new_month, new_day, day_count
//  rsp      out  rsp.valid/ready    cur_year, cur_month, cur_day, year_limited
//
//  a transaction is taken while idle, then the sequencer runs one step per cycle
//  load, step back and the unused code finish in one step
//  add takes one step per month up to january 1, one per whole year, one per
//  month after that, one to place the day and one to finish: at most 112 steps
//  the output register parts the sides: a new transaction is taken while a
//  result still waits; a finished result then holds the sequencer until free
//  rst (synchronous) returns the date to january 1 of the lower year bound
// ----------------------------------------------------------------------------
module calendar_date_add_days
  import cad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cad_req_if.sink   req,
  cad_rsp_if.source rsp
);

  // sequencer and held date
  state_t             state, state_next;
  cmd_t               cmd_q, cmd_q_next;
  logic [YEAR_W-1:0]  date_year, date_year_next;
  logic [MONTH_W-1:0] date_month, date_month_next;
  logic [DAY_W-1:0]   date_day, date_day_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               flag, flag_next;

  // captured load operands
  logic [YEAR_W-1:0]  ld_year, ld_year_next;
  logic [MONTH_W-1:0] ld_month, ld_month_next;
  logic [DAY_W-1:0]   ld_day, ld_day_next;

  // output register
  logic               out_valid, out_valid_next;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic               out_flag;
  logic               out_load;

  // shared walk unit
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   left;
  logic [YLEN_W-1:0]  ylen;
  logic               jump_ok;
  logic [COUNT_W-1:0] sub_amt;
  logic [COUNT_W-1:0] count_diff;
  logic               fits;
  logic               done;

  // load clamp helpers
  logic [YEAR_W-1:0]  cl_year;
  logic [MONTH_W-1:0] cl_month;
  logic [DAY_W-1:0]   cl_len;
  logic [MONTH_W-1:0] prev_month;

  assign req.ready = (state == ST_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.cur_year     = out_year;
  assign rsp.cur_month    = out_month;
  assign rsp.cur_day      = out_day;
  assign rsp.year_limited = out_flag;

  // days left in the month, year length, and whether a whole-year jump applies
  assign cur_len    = month_len(date_month, date_year);
  assign left       = cur_len - date_day;
  assign ylen       = year_len(date_year);
  assign jump_ok    = (date_month == FIRST_MON) && (date_day == FIRST_DAY) &&
                      (date_year < YEAR_HI) &&
                      (count >= {{(COUNT_W-YLEN_W){1'b0}}, ylen});
  assign fits       = (count <= {{(COUNT_W-DAY_W){1'b0}}, left});
  assign sub_amt    = jump_ok ? {{(COUNT_W-YLEN_W){1'b0}}, ylen}
                              : {{(COUNT_W-DAY_W){1'b0}}, left} + COUNT_W'(1);
  assign count_diff = count - sub_amt;
  assign prev_month = date_month - FIRST_MON;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      date_year  <= YEAR_LO;
      date_month <= FIRST_MON;
      date_day   <= FIRST_DAY;
      cmd_q      <= CMD_NOP;
      count      <= '0;
      flag       <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      date_year  <= date_year_next;
      date_month <= date_month_next;
      date_day   <= date_day_next;
      cmd_q      <= cmd_q_next;
      count      <= count_next;
      flag       <= flag_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_year  <= ld_year_next;
    ld_month <= ld_month_next;
    ld_day   <= ld_day_next;
    if (out_load) begin
      out_year  <= date_year_next;
      out_month <= date_month_next;
      out_day   <= date_day_next;
      out_flag  <= flag_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    date_year_next  = date_year;
    date_month_next = date_month;
    date_day_next   = date_day;
    count_next      = count;
    flag_next       = flag;
    ld_year_next    = ld_year;
    ld_month_next   = ld_month;
    ld_day_next     = ld_day;
    out_load        = 1'b0;
    done            = 1'b0;
    cl_year         = ld_year;
    cl_month        = ld_month;
    cl_len          = LAST_DAY;

    // result taken downstream frees the output register
    out_valid_next  = out_valid && !rsp.ready;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_q_next    = cmd_t'(req.cmd);
          ld_year_next  = req.new_year;
          ld_month_next = req.new_month;
          ld_day_next   = req.new_day;
          count_next    = req.day_count;
          flag_next     = 1'b0;
          state_next    = ST_RUN;
        end
      end

      ST_RUN: begin
        unique case (cmd_q)
          CMD_LOAD: begin
            // year to bounds, month to 1..12, day to 1..month length
            if (ld_year < YEAR_LO) begin
              cl_year   = YEAR_LO;
              flag_next = 1'b1;
            end else if (ld_year > YEAR_HI) begin
              cl_year   = YEAR_HI;
              flag_next = 1'b1;
            end
            if (ld_month < FIRST_MON) begin
              cl_month = FIRST_MON;
            end else if (ld_month > LAST_MON) begin
              cl_month = LAST_MON;
            end
            cl_len          = month_len(cl_month, cl_year);
            date_year_next  = cl_year;
            date_month_next = cl_month;
            if (ld_day < FIRST_DAY) begin
              date_day_next = FIRST_DAY;
            end else if (ld_day > cl_len) begin
              date_day_next = cl_len;
            end else begin
              date_day_next = ld_day;
            end
            done = 1'b1;
          end

          CMD_ADD: begin
            if (count == '0) begin
              done = 1'b1;
            end else if (jump_ok) begin
              // whole year from january 1
              date_year_next = date_year + YEAR_W'(1);
              count_next     = count_diff;
            end else if (fits) begin
              date_day_next = date_day + count[DAY_W-1:0];
              count_next    = '0;
            end else begin
              count_next = count_diff;
              if (date_month >= LAST_MON) begin
                if (date_year >= YEAR_HI) begin
                  // saturate at the last day of the top year
                  date_month_next = LAST_MON;
                  date_day_next   = LAST_DAY;
                  flag_next       = 1'b1;
                  count_next      = '0;
                end else begin
                  date_year_next  = date_year + YEAR_W'(1);
                  date_month_next = FIRST_MON;
                  date_day_next   = FIRST_DAY;
                end
              end else begin
                date_month_next = date_month + MONTH_W'(1);
                date_day_next   = FIRST_DAY;
              end
            end
          end

          CMD_BACK: begin
            if (date_day > FIRST_DAY) begin
              date_day_next = date_day - DAY_W'(1);
            end else if (date_month > FIRST_MON) begin
              date_month_next = prev_month;
              date_day_next   = month_len(prev_month, date_year);
            end else begin
              // december 31 of the previous year, held at the lower bound
              if (date_year <= YEAR_LO) begin
                date_year_next = YEAR_LO;
                flag_next      = 1'b1;
              end else begin
                date_year_next = date_year - YEAR_W'(1);
              end
              date_month_next = LAST_MON;
              date_day_next   = LAST_DAY;
            end
            done = 1'b1;
          end

          CMD_NOP: begin
            done = 1'b1;
          end

          default: begin
            done = 1'b1;
          end
        endcase
      end

      ST_HOLD: begin
        done = 1'b1;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // hand the result to the output register, or wait for it to drain
    if (done) begin
      if (!out_valid || rsp.ready) begin
        out_load       = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end else begin
        state_next = ST_HOLD;
      end
    end
  end

endmodule
